/* design/cett_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the clock edge tap tempo unit.
// Depends on nothing; every other design file imports it.
package cett_pkg;

  // Depth of the interval history and width of the time base.
  localparam int HISTORY_DEPTH = 3;
  localparam int TIME_W        = 32;

  // Fixed field widths.
  localparam int CV_W    = 16;
  localparam int BASE_W  = 24;
  localparam int ALPHA_W = 16;
  localparam int MS_W    = 16;

  // Derived widths for the history ring, its fill count and the running sum.
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = MS_W + CNT_W;

  // Reset values of the tracked state.
  localparam logic [BASE_W-1:0] BASE_RESET = 24'h800000;
  localparam logic [MS_W-1:0]   AVG_RESET  = 16'd500;

  // Interval limits handed to the tempo tracker.
  typedef struct packed {
    logic [MS_W-1:0] min_ms;
    logic [MS_W-1:0] max_ms;
  } cett_limits_t;

  // One beat registration request.
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] now;
  } cett_beat_req_t;

endpackage

/* design/clock_edge_tap_tempo_unit.sv */
`timescale 1ns / 1ps
// Top level of the clock edge tap tempo unit: register file, detector and control.
// Depends on cett_pkg, cett_smoother and cett_tempo.
//
// Each item is one millisecond tick (CV sample, timestamp, tap) and yields one
// result item. Items are handled one at a time; in_ready_o is high only while
// the block waits for the next tick, and a finished result sits in an output
// register so the next tick can be taken before it is collected. A tick that
// settles or tracks the baseline runs the bit-serial multiplier that walks the
// 16 bits of alpha. An interval that enters the history is summed entry by
// entry and then averaged by the serial divider, which retires one bit of the
// 18-bit sum per cycle. A tick may register both a clock beat and a tap.
module clock_edge_tap_tempo_unit import cett_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Tick channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CV_W-1:0] cv_sample_i,
  input  logic [31:0]     now_ms_i,
  input  logic            tap_i,
  // Result channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            beat_o,
  output logic [MS_W-1:0] interval_avg_ms_o,
  output logic            armed_o,
  output logic            settling_o,
  // Configuration port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  typedef enum logic [2:0] {S_IDLE, S_SMOOTH, S_DETECT, S_BEAT, S_OUT} state_e;

  // Register map, one word per register.
  localparam logic [2:0] REG_RISE   = 3'd0;
  localparam logic [2:0] REG_REARM  = 3'd1;
  localparam logic [2:0] REG_SETTLE = 3'd2;
  localparam logic [2:0] REG_FAST   = 3'd3;
  localparam logic [2:0] REG_SLOW   = 3'd4;
  localparam logic [2:0] REG_MIN    = 3'd5;
  localparam logic [2:0] REG_MAX    = 3'd6;

  state_e            state_q;
  logic [15:0]       rise_q;
  logic [15:0]       rearm_q;
  logic [7:0]        settle_ticks_q;
  logic [15:0]       fast_q;
  logic [15:0]       slow_q;
  logic [MS_W-1:0]   min_q;
  logic [MS_W-1:0]   max_q;
  logic [7:0]        settle_left_q;
  logic              armed_q;
  logic [CV_W-1:0]   cv_q;
  logic [TIME_W-1:0] now_q;
  logic              tap_q;
  logic              settling_q;
  logic              beat_q;
  logic              tap_pend_q;
  logic              out_valid_q;
  logic              beat_out_q;
  logic [MS_W-1:0]   avg_out_q;
  logic              armed_out_q;
  logic              settling_out_q;

  logic              cfg_wr;
  logic [2:0]        reg_idx;
  logic              in_fire;
  logic              need_smooth;
  logic              sm_start;
  logic [ALPHA_W-1:0] sm_alpha;
  logic              sm_busy;
  logic              sm_done;
  logic [BASE_W-1:0] baseline;
  logic [BASE_W:0]   cv_wide;
  logic [BASE_W:0]   rise_level;
  logic [BASE_W:0]   rearm_level;
  logic              rise_hit;
  logic              rearm_miss;
  logic              clk_beat;
  logic              out_load;
  cett_beat_req_t    beat_req;
  cett_limits_t      limits;
  logic              tp_busy;
  logic              tp_done;
  logic [MS_W-1:0]   tp_avg;

  // Configuration port decode.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q         <= 16'd13107;
      rearm_q        <= 16'd4588;
      settle_ticks_q <= 8'd200;
      fast_q         <= 16'd13107;
      slow_q         <= 16'd1311;
      min_q          <= 16'd40;
      max_q          <= 16'd8000;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RISE:   rise_q         <= pwdata[15:0];
        REG_REARM:  rearm_q        <= pwdata[15:0];
        REG_SETTLE: settle_ticks_q <= pwdata[7:0];
        REG_FAST:   fast_q         <= pwdata[15:0];
        REG_SLOW:   slow_q         <= pwdata[15:0];
        REG_MIN:    min_q          <= pwdata[15:0];
        REG_MAX:    max_q          <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_RISE:   prdata = {16'd0, rise_q};
      REG_REARM:  prdata = {16'd0, rearm_q};
      REG_SETTLE: prdata = {24'd0, settle_ticks_q};
      REG_FAST:   prdata = {16'd0, fast_q};
      REG_SLOW:   prdata = {16'd0, slow_q};
      REG_MIN:    prdata = {16'd0, min_q};
      REG_MAX:    prdata = {16'd0, max_q};
      default:    prdata = 32'd0;
    endcase
  end

  // A tick that settles or finds the detector disarmed updates the baseline first.
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign need_smooth = (settle_left_q != 8'd0) || !armed_q;
  assign sm_start    = in_fire && need_smooth;
  assign sm_alpha    = (settle_left_q != 8'd0) ? fast_q : slow_q;

  cett_smoother u_smoother (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sm_start),
    .cv_i       (cv_sample_i),
    .alpha_i    (sm_alpha),
    .busy_o     (sm_busy),
    .done_o     (sm_done),
    .baseline_o (baseline)
  );

  // Edge detector levels, compared one bit wider so the sums cannot wrap.
  assign cv_wide     = {1'b0, cv_q, 8'd0};
  assign rise_level  = {1'b0, baseline} + {1'b0, rise_q, 8'd0};
  assign rearm_level = {1'b0, baseline} + {1'b0, rearm_q, 8'd0};
  assign rise_hit    = cv_wide > rise_level;
  assign rearm_miss  = cv_wide < rearm_level;
  assign clk_beat    = !settling_q && !armed_q && rise_hit;

  // Beat requests: the clock beat goes first, a tap follows on the same tick.
  assign beat_req.start = ((state_q == S_DETECT) && (clk_beat || tap_q)) ||
                          ((state_q == S_BEAT) && tp_done && tap_pend_q);
  assign beat_req.now   = now_q;
  assign limits.min_ms  = min_q;
  assign limits.max_ms  = max_q;

  cett_tempo u_tempo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (beat_req),
    .lim_i  (limits),
    .busy_o (tp_busy),
    .done_o (tp_done),
    .avg_o  (tp_avg)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Tick sequencer, detector state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      settle_left_q <= 8'd200;
      armed_q       <= 1'b0;
      tap_pend_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cv_q       <= cv_sample_i;
            now_q      <= now_ms_i[TIME_W-1:0];
            tap_q      <= tap_i;
            settling_q <= (settle_left_q != 8'd0);
            state_q    <= need_smooth ? S_SMOOTH : S_DETECT;
          end
        end
        S_SMOOTH: begin
          if (sm_done) begin
            state_q <= S_DETECT;
          end
        end
        S_DETECT: begin
          if (settling_q) begin
            settle_left_q <= settle_left_q - 8'd1;
          end else if (!armed_q) begin
            if (rise_hit) begin
              armed_q <= 1'b1;
            end
          end else if (rearm_miss) begin
            armed_q <= 1'b0;
          end
          beat_q     <= clk_beat || tap_q;
          tap_pend_q <= clk_beat && tap_q;
          state_q    <= (clk_beat || tap_q) ? S_BEAT : S_OUT;
        end
        S_BEAT: begin
          if (tp_done) begin
            if (tap_pend_q) begin
              tap_pend_q <= 1'b0;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            beat_out_q     <= beat_q;
            avg_out_q      <= tp_avg;
            armed_out_q    <= armed_q;
            settling_out_q <= settling_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Writing the settle count restarts the settling phase.
      if (cfg_wr && (reg_idx == REG_SETTLE)) begin
        settle_left_q <= pwdata[7:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign beat_o            = beat_out_q;
  assign interval_avg_ms_o = avg_out_q;
  assign armed_o           = armed_out_q;
  assign settling_o        = settling_out_q;

  // Only one item is in flight: an accepted tick blocks the next one.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("tick accepted while another item was in flight");

  // The baseline smoother and the tempo tracker never run at the same time.
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sm_busy && tp_busy))
    else $error("smoother and tempo tracker busy together");

  // The detector arms only from a detection step outside the settling phase.
  a_arm_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(armed_q) |-> ($past(state_q) == S_DETECT) && !$past(settling_q))
    else $error("detector armed outside a detection step");

endmodule

/* design/cett_smoother.sv */
`timescale 1ns / 1ps
// Baseline tracker: exponential smoother with a bit-serial multiplier.
// Depends on cett_pkg.
module cett_smoother import cett_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CV_W-1:0]    cv_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [BASE_W-1:0]  baseline_o
);

  typedef enum logic [1:0] {SM_IDLE, SM_MUL, SM_UPD} sm_state_e;

  localparam int STEP_W = $clog2(ALPHA_W);

  sm_state_e          state_q;
  logic [BASE_W-1:0]  base_q;
  logic [BASE_W-1:0]  mag_q;
  logic [BASE_W-1:0]  hi_q;
  logic [ALPHA_W-1:0] lo_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [STEP_W-1:0]  step_q;
  logic               neg_q;
  logic               done_q;

  logic [BASE_W-1:0]  cv24;
  logic               cv_below;
  logic [BASE_W:0]    add_sum;
  logic [BASE_W-1:0]  down_mag;

  // The sample is widened to Q0.24 by appending zero bits.
  assign cv24     = {cv_i, {(BASE_W - CV_W){1'b0}}};
  assign cv_below = cv24 < base_q;

  // One partial product per cycle, weight bit taken from the LSB of alpha.
  assign add_sum  = {1'b0, hi_q} + {1'b0, (alpha_q[0] ? mag_q : {BASE_W{1'b0}})};

  // A downward step rounds away from zero, which is a floor of the signed step.
  assign down_mag = hi_q + {{(BASE_W - 1){1'b0}}, |lo_q};

  // Sequencer: load magnitude, shift-add over all alpha bits, then update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SM_IDLE;
      base_q  <= BASE_RESET;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SM_IDLE: begin
          if (start_i) begin
            neg_q   <= cv_below;
            mag_q   <= cv_below ? (base_q - cv24) : (cv24 - base_q);
            alpha_q <= alpha_i;
            hi_q    <= '0;
            lo_q    <= '0;
            step_q  <= '0;
            state_q <= SM_MUL;
          end
        end
        SM_MUL: begin
          hi_q    <= add_sum[BASE_W:1];
          lo_q    <= {add_sum[0], lo_q[ALPHA_W-1:1]};
          alpha_q <= {1'b0, alpha_q[ALPHA_W-1:1]};
          step_q  <= step_q + 1'b1;
          if (step_q == STEP_W'(ALPHA_W - 1)) begin
            state_q <= SM_UPD;
          end
        end
        SM_UPD: begin
          base_q  <= neg_q ? (base_q - down_mag) : (base_q + hi_q);
          done_q  <= 1'b1;
          state_q <= SM_IDLE;
        end
        default: state_q <= SM_IDLE;
      endcase
    end
  end

  assign busy_o     = (state_q != SM_IDLE);
  assign done_o     = done_q;
  assign baseline_o = base_q;

endmodule

/* design/cett_divider.sv */
`timescale 1ns / 1ps
// Restoring divider that retires one quotient bit per cycle.
// Divides the interval sum by the ring fill count. Depends on cett_pkg.
module cett_divider import cett_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int BIT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] qr_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] div_q;
  logic [BIT_W-1:0] bit_q;
  logic             run_q;
  logic             done_q;

  logic [CNT_W:0]   trial;
  logic             fits;

  // Bring down the next dividend bit and test against the divisor.
  assign trial = {rem_q, qr_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !run_q) begin
        qr_q  <= dividend_i;
        rem_q <= '0;
        div_q <= divisor_i;
        bit_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
        qr_q  <= {qr_q[SUM_W-2:0], fits};
        bit_q <= bit_q + 1'b1;
        if (bit_q == BIT_W'(SUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = qr_q;

endmodule

/* design/cett_tempo.sv */
`timescale 1ns / 1ps
// Tempo tracker: beat intervals, the interval history ring and its average.
// Depends on cett_pkg and cett_divider.
module cett_tempo import cett_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cett_beat_req_t req_i,
  input  cett_limits_t   lim_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [MS_W-1:0] avg_o
);

  typedef enum logic [2:0] {TP_IDLE, TP_CHECK, TP_READ, TP_ADD, TP_DIV} tp_state_e;

  tp_state_e         state_q;
  logic [TIME_W-1:0] last_q;
  logic              last_vld_q;
  logic [TIME_W-1:0] iv_q;
  logic [MS_W-1:0]   ring_q [HISTORY_DEPTH];
  logic [MS_W-1:0]   rd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  sel_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [MS_W-1:0]   avg_q;
  logic              done_q;
  logic              div_go_q;

  logic              in_range;
  logic              too_long;
  logic              ring_we;
  logic              sel_last;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;

  // Interval classification against the configured limits.
  assign in_range = (iv_q >= TIME_W'(lim_i.min_ms)) && (iv_q <= TIME_W'(lim_i.max_ms));
  assign too_long = iv_q > TIME_W'(lim_i.max_ms);
  assign ring_we  = (state_q == TP_CHECK) && in_range;
  assign sel_last = (CNT_W'(sel_q) + CNT_W'(1)) == cnt_q;

  // History ring: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[idx_q] <= iv_q[MS_W-1:0];
    end
    rd_q <= ring_q[sel_q];
  end

  // Average of the filled entries, one quotient bit per cycle.
  cett_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Beat sequencer: measure, store, sum the ring entry by entry, divide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= TP_IDLE;
      last_q     <= '0;
      last_vld_q <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
      avg_q      <= AVG_RESET;
      done_q     <= 1'b0;
      div_go_q   <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      unique case (state_q)
        TP_IDLE: begin
          if (req_i.start) begin
            iv_q       <= req_i.now - last_q;
            last_q     <= req_i.now;
            last_vld_q <= 1'b1;
            if (last_vld_q) begin
              state_q <= TP_CHECK;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        TP_CHECK: begin
          if (in_range) begin
            idx_q <= (idx_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : idx_q + 1'b1;
            if (cnt_q != CNT_W'(HISTORY_DEPTH)) begin
              cnt_q <= cnt_q + 1'b1;
            end
            sel_q   <= '0;
            sum_q   <= '0;
            state_q <= TP_READ;
          end else begin
            // An interval beyond the upper limit empties the history.
            if (too_long) begin
              cnt_q <= '0;
              idx_q <= '0;
            end
            done_q  <= 1'b1;
            state_q <= TP_IDLE;
          end
        end
        TP_READ: begin
          state_q <= TP_ADD;
        end
        TP_ADD: begin
          sum_q <= sum_q + SUM_W'(rd_q);
          if (sel_last) begin
            div_go_q <= 1'b1;
            state_q  <= TP_DIV;
          end else begin
            sel_q   <= sel_q + 1'b1;
            state_q <= TP_READ;
          end
        end
        TP_DIV: begin
          if (div_done) begin
            avg_q   <= quotient[MS_W-1:0];
            done_q  <= 1'b1;
            state_q <= TP_IDLE;
          end
        end
        default: state_q <= TP_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != TP_IDLE);
  assign done_o = done_q;
  assign avg_o  = avg_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for clock_edge_tap_tempo_unit: directed rows, then random phases.
// Depends on cett_pkg and the unit's RTL; expected results are typed in the plan or tracked.
module tb;
  import cett_pkg::*;

  localparam int LIMIT     = 400000;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 80;
  localparam int MAX_SHOWN = 40;

  // Register map, one word per register.
  typedef enum logic [2:0] {
    REG_RISE, REG_REARM, REG_SETTLE, REG_FAST, REG_SLOW, REG_MIN, REG_MAX
  } cfg_reg_e;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic            beat;
    logic [MS_W-1:0] avg;
    logic            armed;
    logic            settling;
  } tick_out_t;

  // One line of the directed plan: a register write or a tick, with an
  // optional hand-written result.
  typedef struct packed {
    row_kind_e       kind;
    cfg_reg_e        target;
    logic [15:0]     val;
    logic [CV_W-1:0] cv;
    logic [31:0]     now;
    logic            tap;
    logic            typed;
    logic            beat;
    logic [MS_W-1:0] avg;
    logic            armed;
    logic            settling;
  } plan_row_t;

  localparam int PLAN_LEN = 32;
  // kind, reg, value, cv, now, tap, typed, beat, avg, armed, settling
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // Right after reset: settling, tap still honored, no interval yet.
    '{ROW_TICK, REG_RISE,   0,      'h0000, 'h0,         0, 1, 0, 500,   0, 1},
    '{ROW_TICK, REG_RISE,   0,      'hFFFF, 'hFFFF_FFFF, 1, 1, 1, 500,   0, 1},
    // End settling, freeze the baseline, trigger on anything above it.
    '{ROW_CFG,  REG_SETTLE, 0,      0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_CFG,  REG_SLOW,   0,      0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_CFG,  REG_RISE,   0,      0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_CFG,  REG_REARM,  'hFFFF, 0,      0,           0, 0, 0, 0,     0, 0},
    // Interval across the time wrap, disarm, short interval, clock plus tap.
    '{ROW_TICK, REG_RISE,   0,      'hFFFF, 99,          0, 1, 1, 100,   1, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 100,         0, 1, 0, 100,   0, 0},
    '{ROW_TICK, REG_RISE,   0,      'hFFFF, 120,         1, 1, 1, 100,   1, 0},
    '{ROW_TICK, REG_RISE,   0,      'hFFFF, 300,         0, 1, 0, 100,   0, 0},
    '{ROW_TICK, REG_RISE,   0,      'hFFFF, 500,         0, 1, 1, 240,   1, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 510,         0, 1, 0, 240,   0, 0},
    // Long interval clears the history but keeps the average.
    '{ROW_TICK, REG_RISE,   0,      'hFFFF, 10000,       0, 1, 1, 240,   1, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 10010,       1, 1, 1, 240,   0, 0},
    // Refill the history by taps, wrap it and truncate the mean.
    '{ROW_TICK, REG_RISE,   0,      'h0000, 10110,       1, 1, 1, 100,   0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 10310,       1, 1, 1, 150,   0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 10610,       1, 1, 1, 200,   0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 11010,       1, 1, 1, 300,   0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 11111,       1, 1, 1, 267,   0, 0},
    // Crossed limits: nothing is accepted, longer than max still clears.
    '{ROW_CFG,  REG_MIN,    'hFFFF, 0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_CFG,  REG_MAX,    0,      0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 11200,       1, 1, 1, 267,   0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 11200,       1, 1, 1, 267,   0, 0},
    // Widest window: the largest and the zero interval both enter.
    '{ROW_CFG,  REG_MIN,    0,      0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_CFG,  REG_MAX,    'hFFFF, 0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 76735,       1, 1, 1, 65535, 0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h0000, 76735,       1, 1, 1, 32767, 0, 0},
    // Restart settling with the fastest weight; these rows use the tracker.
    '{ROW_CFG,  REG_FAST,   'hFFFF, 0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_CFG,  REG_SETTLE, 2,      0,      0,           0, 0, 0, 0,     0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h1234, 76800,       0, 0, 0, 0,     0, 0},
    '{ROW_TICK, REG_RISE,   0,      'h8000, 76900,       0, 0, 0, 0,     0, 0},
    '{ROW_TICK, REG_RISE,   0,      'hFFFF, 77000,       0, 0, 0, 0,     0, 0}
  };

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [CV_W-1:0] cv_sample_i;
  logic [31:0]     now_ms_i;
  logic            tap_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic            beat_o;
  logic [MS_W-1:0] interval_avg_ms_o;
  logic            armed_o;
  logic            settling_o;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [4:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  clock_edge_tap_tempo_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cv_sample_i       (cv_sample_i),
    .now_ms_i          (now_ms_i),
    .tap_i             (tap_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .beat_o            (beat_o),
    .interval_avg_ms_o (interval_avg_ms_o),
    .armed_o           (armed_o),
    .settling_o        (settling_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Tempo tracker: configuration copy.
  logic [15:0]        rise_thr, rearm_thr, alpha_fast, alpha_slow, min_ms, max_ms;
  // Tempo tracker: state copy.
  logic [BASE_W-1:0]  base_q;
  logic               armed_q;
  logic [7:0]         settle_left;
  logic [31:0]        last_ms;
  logic               last_ok;
  logic [MS_W-1:0]    hist [HISTORY_DEPTH];
  int                 hist_idx;
  int                 hist_cnt;
  logic [MS_W-1:0]    avg_ms;

  // Results still owed by the unit, oldest first.
  tick_out_t          pending_q [$];

  int    fail_count;
  int    cycle_cnt;
  int    ticks_sent;
  int    cfg_writes;
  int    results_seen;
  int    beats_seen;
  bit    idle_on;
  int    rx_hold;
  logic [31:0] clock_ms;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Records one failure; the printout is capped to keep the log short.
  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Moves the baseline toward the sample by alpha/65536 of the gap, rounding down.
  function automatic void smooth_toward(input logic [CV_W-1:0] cv,
                                        input logic [15:0] alpha);
    longint target;
    longint delta;
    longint step;
    target = longint'({cv, 8'h00});
    delta  = target - longint'(base_q);
    step   = (delta * longint'(alpha)) >>> 16;
    base_q = BASE_W'(longint'(base_q) + step);
  endfunction

  // Registers a beat: measures the interval and updates the history and its mean.
  function automatic void log_beat(input logic [31:0] now);
    logic [31:0] gap;
    int unsigned total;
    if (last_ok) begin
      gap = now - last_ms;
      if (gap >= {16'h0, min_ms} && gap <= {16'h0, max_ms}) begin
        hist[hist_idx] = gap[MS_W-1:0];
        hist_idx = (hist_idx == HISTORY_DEPTH - 1) ? 0 : hist_idx + 1;
        if (hist_cnt < HISTORY_DEPTH) hist_cnt++;
        total = 0;
        for (int k = 0; k < hist_cnt; k++) total += hist[k];
        avg_ms = MS_W'(total / hist_cnt);
      end else if (gap > {16'h0, max_ms}) begin
        hist_cnt = 0;
        hist_idx = 0;
      end
    end
    last_ms = now;
    last_ok = 1'b1;
  endfunction

  // Advances the tracker by one tick and returns the result it should produce.
  function automatic tick_out_t track_tick(input logic [CV_W-1:0] cv,
                                           input logic [31:0] now, input logic tap);
    tick_out_t   r;
    logic [31:0] cv24;
    cv24 = {8'h00, cv, 8'h00};
    r = '0;
    if (settle_left != 0) begin
      settle_left--;
      r.settling = 1'b1;
      smooth_toward(cv, alpha_fast);
    end else if (!armed_q) begin
      smooth_toward(cv, alpha_slow);
      if (cv24 > {8'h00, base_q} + {8'h00, rise_thr, 8'h00}) begin
        armed_q = 1'b1;
        log_beat(now);
        r.beat = 1'b1;
      end
    end else if (cv24 < {8'h00, base_q} + {8'h00, rearm_thr, 8'h00}) begin
      armed_q = 1'b0;
    end
    if (tap) begin
      log_beat(now);
      r.beat = 1'b1;
    end
    r.avg   = avg_ms;
    r.armed = armed_q;
    return r;
  endfunction

  // Offers one tick after a random gap and books its expected result on acceptance.
  task automatic send_tick(input logic [CV_W-1:0] cv, input logic [31:0] now,
                           input logic tap, input logic typed, input tick_out_t want);
    int        gap;
    tick_out_t pred;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    cv_sample_i = cv;
    now_ms_i    = now;
    tap_i       = tap;
    do @(posedge clk_i); while (!in_ready_o);
    pred = track_tick(cv, now, tap);
    pending_q.push_back(typed ? want : pred);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering ticks and waits until every owed result has come back.
  task automatic quiesce();
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes one register over the bus, reads it back, and mirrors it in the tracker.
  task automatic set_reg(input cfg_reg_e r, input logic [15:0] v);
    logic [31:0] mask;
    mask    = (r == REG_SETTLE) ? 32'h0000_00FF : 32'h0000_FFFF;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = {16'h0, v} & mask;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== pwdata) flag_mismatch("register readback", pwdata, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    case (r)
      REG_RISE:   rise_thr = v;
      REG_REARM:  rearm_thr = v;
      REG_SETTLE: settle_left = v[7:0];
      REG_FAST:   alpha_fast = v;
      REG_SLOW:   alpha_slow = v;
      REG_MIN:    min_ms = v;
      REG_MAX:    max_ms = v;
      default:    ;
    endcase
    cfg_writes++;
  endtask

  // Picks the settings of one random phase: all-low, all-high, or a typical mix.
  task automatic random_setup(input int p);
    logic [15:0] rise;
    logic [15:0] lo;
    logic [15:0] hi;
    if (p == 1) begin
      set_reg(REG_RISE, 16'h0000);
      set_reg(REG_REARM, 16'h0000);
      set_reg(REG_SETTLE, 16'h0000);
      set_reg(REG_FAST, 16'h0000);
      set_reg(REG_SLOW, 16'h0000);
      set_reg(REG_MIN, 16'h0000);
      set_reg(REG_MAX, 16'h0000);
    end else if (p == 2) begin
      set_reg(REG_RISE, 16'hFFFF);
      set_reg(REG_REARM, 16'hFFFF);
      set_reg(REG_SETTLE, 16'h00FF);
      set_reg(REG_FAST, 16'hFFFF);
      set_reg(REG_SLOW, 16'hFFFF);
      set_reg(REG_MIN, 16'hFFFF);
      set_reg(REG_MAX, 16'hFFFF);
    end else begin
      rise = 16'($urandom_range(16'h0100, 16'h3000));
      lo   = 16'($urandom_range(0, 120));
      hi   = 16'($urandom_range(150, 9000));
      // Now and then the limits cross.
      if ($urandom_range(0, 5) == 0) begin
        lo = 16'($urandom_range(500, 2000));
        hi = 16'($urandom_range(0, 400));
      end
      set_reg(REG_RISE, rise);
      set_reg(REG_REARM, 16'($urandom_range(0, rise)));
      set_reg(REG_SETTLE, 16'($urandom_range(0, 6)));
      set_reg(REG_FAST, 16'($urandom));
      set_reg(REG_SLOW, 16'($urandom_range(0, 16'h4000)));
      set_reg(REG_MIN, lo);
      set_reg(REG_MAX, hi);
    end
  endtask

  // Sends a phase of ticks: mostly a pulse train with advancing time, some noise.
  task automatic run_phase(input int n);
    logic [CV_W-1:0] cv;
    logic [31:0]     now;
    logic            tap;
    logic            high;
    logic [CV_W-1:0] level;
    int              run_left;
    int              pick;
    tick_out_t       none;
    none     = '0;
    high     = 1'b0;
    level    = '0;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        cv  = CV_W'($urandom);
        now = $urandom;
        tap = 1'($urandom_range(0, 1));
      end else begin
        if (run_left == 0) begin
          high     = !high;
          run_left = $urandom_range(1, 6);
          level    = high ? CV_W'($urandom_range(16'hA000, 16'hFFFF))
                          : CV_W'($urandom_range(16'h0000, 16'h3000));
        end
        run_left--;
        cv   = level;
        pick = $urandom_range(0, 19);
        if (pick == 0)      clock_ms = clock_ms;
        else if (pick == 1) clock_ms = clock_ms + $urandom_range(2000, 70000);
        else                clock_ms = clock_ms + $urandom_range(1, 250);
        now = clock_ms;
        tap = ($urandom_range(0, 9) == 0);
      end
      send_tick(cv, now, tap, 1'b0, none);
    end
  endtask

  // Result side: random stalls per item, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      stall = (rx_hold > 0) ? rx_hold : (idle_on ? $urandom_range(0, 11) : 0);
      rx_hold = 0;
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compares every collected result with the oldest owed one.
  always @(posedge clk_i) begin
    tick_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (beat_o) beats_seen++;
      if (pending_q.size() == 0) begin
        flag_mismatch("unrequested result, beat", 0, beat_o);
      end else begin
        want = pending_q.pop_front();
        if (beat_o !== want.beat) flag_mismatch("beat", want.beat, beat_o);
        if (interval_avg_ms_o !== want.avg)
          flag_mismatch("interval_avg_ms", want.avg, interval_avg_ms_o);
        if (armed_o !== want.armed) flag_mismatch("armed", want.armed, armed_o);
        if (settling_o !== want.settling)
          flag_mismatch("settling", want.settling, settling_o);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d results owed",
               $time, cycle_cnt, pending_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus: reset, directed plan, random phases, drain and verdict.
  initial begin
    tick_out_t want;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cv_sample_i = '0;
    now_ms_i    = '0;
    tap_i       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    cycle_cnt   = 0;
    ticks_sent  = 0;
    cfg_writes  = 0;
    results_seen = 0;
    beats_seen  = 0;
    idle_on     = 1'b1;
    rx_hold     = 0;
    clock_ms    = 32'd100000;

    // Tracker starts from the reset state of the unit.
    rise_thr    = 16'd13107;
    rearm_thr   = 16'd4588;
    alpha_fast  = 16'd13107;
    alpha_slow  = 16'd1311;
    min_ms      = 16'd40;
    max_ms      = 16'd8000;
    base_q      = BASE_RESET;
    armed_q     = 1'b0;
    settle_left = 8'd200;
    last_ms     = '0;
    last_ok     = 1'b0;
    for (int k = 0; k < HISTORY_DEPTH; k++) hist[k] = '0;
    hist_idx    = 0;
    hist_cnt    = 0;
    avg_ms      = AVG_RESET;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed plan.
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        quiesce();
        set_reg(PLAN[i].target, PLAN[i].val);
      end else begin
        want = '{beat: PLAN[i].beat, avg: PLAN[i].avg, armed: PLAN[i].armed,
                 settling: PLAN[i].settling};
        send_tick(PLAN[i].cv, PLAN[i].now, PLAN[i].tap, PLAN[i].typed, want);
      end
    end

    // Random phases; every fourth one runs without gaps, and one of those
    // starts with a long hold on the result side so the input backs up.
    for (int p = 0; p < N_PHASES; p++) begin
      quiesce();
      random_setup(p);
      idle_on = (p % 4 != 3);
      if (p == 3) rx_hold = 300;
      run_phase(PHASE_LEN);
    end

    quiesce();
    idle_on = 1'b0;
    repeat (100) @(posedge clk_i);

    $display("Covered %0d ticks in %0d random phases with %0d register writes.",
             ticks_sent, N_PHASES, cfg_writes);
    $display("Compared %0d results, %0d of them carrying a beat; %0d failures.",
             results_seen, beats_seen, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
